// ===== src/bb3_pkg.sv =====
package bb3_pkg;

    // pixel and channel geometry
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     RESET_DIM        = 11'd1024;

    // neighborhood sum (nine 8-bit values plus rounding half) and divisor
    localparam int SUM_W    = 12;
    localparam int CNT_W    = 4;
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;

    typedef struct packed {
        logic accept;    // input transfer, line store access
        logic win_load;  // shift window, register sums
        logic out_load;  // divide and load output register
    } bb3_cmd_t;

    typedef struct packed {
        logic emit;      // accepted slot produces a result
    } bb3_stat_t;

    // ceil(2^RECIP_SH / n) for every neighborhood size; exact over the sum range
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        unique case (n)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

// ===== src/bb3_in_if.sv =====
interface bb3_in_if;
    logic                     valid;
    logic                     ready;
    logic [bb3_pkg::CH_W-1:0] in_red;
    logic [bb3_pkg::CH_W-1:0] in_green;
    logic [bb3_pkg::CH_W-1:0] in_blue;
    logic                     flush;

    modport source (output valid, in_red, in_green, in_blue, flush, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, flush, output ready);
endinterface

// ===== src/bb3_out_if.sv =====
interface bb3_out_if;
    logic                     valid;
    logic                     ready;
    logic [bb3_pkg::CH_W-1:0] out_red;
    logic [bb3_pkg::CH_W-1:0] out_green;
    logic [bb3_pkg::CH_W-1:0] out_blue;
    logic                     last_of_frame;

    modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

// ===== src/bb3_cfg_if.sv =====
interface bb3_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bb3_pkg::CFG_IDX_W-1:0] index;
    logic [bb3_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bb3_linebuf.sv =====
module bb3_linebuf #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic                      wr_bank,
    input  logic [AW-1:0]             addr,
    input  logic [bb3_pkg::PIX_W-1:0] wdata,
    output logic [bb3_pkg::PIX_W-1:0] rdata0,
    output logic [bb3_pkg::PIX_W-1:0] rdata1
);

    logic [bb3_pkg::PIX_W-1:0] bank0_mem [DEPTH];
    logic [bb3_pkg::PIX_W-1:0] bank1_mem [DEPTH];
    logic [bb3_pkg::PIX_W-1:0] rd0_reg;
    logic [bb3_pkg::PIX_W-1:0] rd1_reg;

    // read before write at the same address
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd0_reg <= bank0_mem[addr];
            if (!wr_bank)
            begin
                bank0_mem[addr] <= wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd1_reg <= bank1_mem[addr];
            if (wr_bank)
            begin
                bank1_mem[addr] <= wdata;
            end
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// ===== src/bb3_ctrl.sv =====
module bb3_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bb3_pkg::bb3_stat_t stat,
    output bb3_pkg::bb3_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WIN,
        S_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.win_load = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                cmd.win_load = 1'b1;
                state_next   = stat.emit ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                // wait for the output register to free up
                cmd.out_load = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_to_win: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_WIN)
        else $error("accepted slot did not reach window stage");

    a_silent_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WIN && !stat.emit) |=> state_reg == S_IDLE)
        else $error("silent slot went on to divide");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== src/bb3_dp.sv =====
module bb3_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bb3_pkg::bb3_cmd_t             cmd,
    output bb3_pkg::bb3_stat_t            stat,
    input  logic [bb3_pkg::CH_W-1:0]      in_red,
    input  logic [bb3_pkg::CH_W-1:0]      in_green,
    input  logic [bb3_pkg::CH_W-1:0]      in_blue,
    input  logic                          flush,
    input  logic                          cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
    output logic [bb3_pkg::CH_W-1:0]      out_red,
    output logic [bb3_pkg::CH_W-1:0]      out_green,
    output logic [bb3_pkg::CH_W-1:0]      out_blue,
    output logic                          last_of_frame
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 3);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WCW = (WW > bb3_pkg::CFG_W) ? WW : bb3_pkg::CFG_W;
    localparam int HCW = (HW > bb3_pkg::CFG_W) ? HW : bb3_pkg::CFG_W;
    localparam int CH  = bb3_pkg::CH_W;
    localparam int SW  = bb3_pkg::SUM_W;
    localparam int PW  = bb3_pkg::PROD_W;
    localparam int RS  = bb3_pkg::RECIP_SH;
    localparam int NW  = bb3_pkg::CNT_W;

    // configuration and effective frame size
    logic [bb3_pkg::CFG_W-1:0] width_cfg_reg;
    logic [bb3_pkg::CFG_W-1:0] height_cfg_reg;
    logic [WCW-1:0]            w_raw;
    logic [HCW-1:0]            h_raw;
    logic [WW-1:0]             eff_w;
    logic [HW-1:0]             eff_h;

    // raster counters
    logic [RW-1:0] in_row_reg;
    logic [RW-1:0] in_row_next;
    logic [WW-1:0] in_col_reg;
    logic [WW-1:0] in_col_next;
    logic [HW-1:0] out_row_reg;
    logic [HW-1:0] out_row_next;
    logic [WW-1:0] out_col_reg;
    logic [WW-1:0] out_col_next;
    logic          restart;

    // accepted slot
    logic [bb3_pkg::PIX_W-1:0] px;
    logic [bb3_pkg::PIX_W-1:0] px_reg;
    logic                      parity_reg;
    logic                      emit_reg;
    logic [bb3_pkg::PIX_W-1:0] rdata0;
    logic [bb3_pkg::PIX_W-1:0] rdata1;
    logic [bb3_pkg::PIX_W-1:0] top;
    logic [bb3_pkg::PIX_W-1:0] mid;

    // window and neighborhood sums
    logic [bb3_pkg::PIX_W-1:0] win_reg  [9];
    logic [bb3_pkg::PIX_W-1:0] win_next [9];
    logic [2:0]                row_ok;
    logic [2:0]                col_ok;
    logic                      top_v;
    logic                      bot_v;
    logic                      left_v;
    logic                      right_v;
    logic [NW-1:0]             n_next;
    logic [NW-1:0]             n_reg;
    logic [2:0][SW-1:0]        acc_next;
    logic [2:0][SW-1:0]        acc_reg;
    logic                      last_reg;

    // reciprocal multiply
    logic [bb3_pkg::RECIP_W-1:0] recip_m;
    logic [2:0][PW-1:0]          prod;
    logic                        prod_ovf;
    logic [2:0][CH-1:0]          q_reg;
    logic                        out_last_reg;

    assign w_raw = WCW'(width_cfg_reg);
    assign h_raw = HCW'(height_cfg_reg);
    assign eff_w = (width_cfg_reg == '0) ? WW'(1) :
                   (w_raw > WCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_raw);
    assign eff_h = (height_cfg_reg == '0) ? HW'(1) :
                   (h_raw > HCW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= bb3_pkg::RESET_DIM;
            height_cfg_reg <= bb3_pkg::RESET_DIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bb3_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                bb3_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                default:                   width_cfg_reg  <= width_cfg_reg;
            endcase
        end
    end

    // frame restarts on any register write and after the last pixel
    assign restart = cfg_we || (cmd.out_load && last_reg);

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (restart)
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (in_col_reg >= eff_w - WW'(1))
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + WW'(1);
                end
            end
            if (cmd.out_load)
            begin
                if (out_col_reg >= eff_w - WW'(1))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + WW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            emit_reg    <= 1'b0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            if (cmd.accept)
            begin
                // result due once the slot index reaches width + 1
                emit_reg <= (in_row_reg >= RW'(2)) ||
                            (in_row_reg == RW'(1) && in_col_reg != '0);
            end
        end
    end

    assign stat.emit = emit_reg;

    // flush slots enter as black
    assign px = flush ? '0 : {in_red, in_green, in_blue};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg     <= px;
            parity_reg <= in_row_reg[0];
        end
    end

    bb3_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_linebuf (
        .clk     (clk),
        .en      (cmd.accept),
        .wr_bank (in_row_reg[0]),
        .addr    (in_col_reg[AW-1:0]),
        .wdata   (px),
        .rdata0  (rdata0),
        .rdata1  (rdata1)
    );

    // bank of the current row parity holds row r-2, the other one row r-1
    assign top = parity_reg ? rdata1 : rdata0;
    assign mid = parity_reg ? rdata0 : rdata1;

    assign top_v   = (out_row_reg != '0);
    assign bot_v   = !(out_row_reg >= eff_h - HW'(1));
    assign left_v  = (out_col_reg != '0);
    assign right_v = !(out_col_reg >= eff_w - WW'(1));
    assign row_ok  = {bot_v, 1'b1, top_v};
    assign col_ok  = {right_v, 1'b1, left_v};

    always_comb
    begin
        logic [SW-1:0] row_sum;
        logic [SW-1:0] total;
        logic [NW-1:0] n_rows;
        logic [NW-1:0] n_cols;
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = px_reg;

        n_rows = NW'(1) + NW'(top_v) + NW'(bot_v);
        n_cols = NW'(1) + NW'(left_v) + NW'(right_v);
        n_next = NW'(n_rows * n_cols);

        for (int c = 0; c < 3; c++)
        begin
            total = SW'(n_next >> 1);
            for (int dr = 0; dr < 3; dr++)
            begin
                row_sum = '0;
                for (int dc = 0; dc < 3; dc++)
                begin
                    if (row_ok[dr] && col_ok[dc])
                    begin
                        row_sum = row_sum + SW'(win_next[dr*3 + dc][c*CH +: CH]);
                    end
                end
                total = total + row_sum;
            end
            acc_next[c] = total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (restart)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (cmd.win_load)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_load)
        begin
            acc_reg  <= acc_next;
            n_reg    <= n_next;
            last_reg <= !bot_v && !right_v;
        end
    end

    // (sum + n/2) / n as a multiply by the rounded-up reciprocal
    assign recip_m = bb3_pkg::recip(n_reg);

    always_comb
    begin
        prod_ovf = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            prod[c]  = PW'(acc_reg[c]) * PW'(recip_m);
            prod_ovf = prod_ovf || (prod[c][PW-1:RS+CH] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int c = 0; c < 3; c++)
            begin
                q_reg[c] <= prod[c][RS +: CH];
            end
            out_last_reg <= last_reg;
        end
    end

    assign out_red       = q_reg[2];
    assign out_green     = q_reg[1];
    assign out_blue      = q_reg[0];
    assign last_of_frame = out_last_reg;

    a_divisor_size: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_load |=> (n_reg == NW'(1) || n_reg == NW'(2) || n_reg == NW'(3) ||
                          n_reg == NW'(4) || n_reg == NW'(6) || n_reg == NW'(9)))
        else $error("neighborhood size out of set");

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !prod_ovf)
        else $error("mean exceeds channel range");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_col_reg < eff_w) && (out_col_reg < eff_w))
        else $error("column counter beyond frame width");

endmodule

// ===== src/box_blur_3x3_rgb.sv =====
// 3x3 box blur over an RGB pixel stream in raster order. Every pixel of an
// image_width x image_height frame comes out as the mean of the in-frame pixels
// of its 3x3 neighborhood (4 at corners, 6 on edges, 9 inside), rounded half
// up per channel. Result (r,c) leaves after input slot r*W + c + W + 1, so a
// frame takes H*W + W + 1 input transfers: the pixels, then W + 1 transfers
// with flush set to drain the tail; last_of_frame marks pixel (H-1, W-1), and
// the next transfer starts a new frame. A transfer with no result passes the
// accept and window steps, one with a result the divide step as well (accept
// and line store read, window shift and neighborhood sum, reciprocal multiply
// into the output register); the output register lets the next pixel in while
// a result waits. Writing either size register (0 acts as 1, values above
// MAX_WIDTH / MAX_HEIGHT clamp) restarts the frame; write only while no result
// is pending. The line store needs no clearing after reset.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    bb3_in_if.sink          pixels,
    bb3_out_if.source       results,
    bb3_cfg_if.sink         cfg
);

    bb3_pkg::bb3_cmd_t  cmd;
    bb3_pkg::bb3_stat_t stat;
    logic               cfg_we;

    // size registers are always writable
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // sequencer: one pixel at a time through accept, window and divide steps
    bb3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixels.valid),
        .in_ready  (pixels.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // counters, line store, window, sums and reciprocal divide
    bb3_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_red        (pixels.in_red),
        .in_green      (pixels.in_green),
        .in_blue       (pixels.in_blue),
        .flush         (pixels.flush),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_red       (results.out_red),
        .out_green     (results.out_green),
        .out_blue      (results.out_blue),
        .last_of_frame (results.last_of_frame)
    );

endmodule
